### hw/rtl/bal_pkg.sv
// Shared constants, opcodes and types for the bounded array list.
`timescale 1ns / 1ps
package bal_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VALUE_W  = 32;
   localparam int OPCODE_W = 2;
   localparam int POS_W    = 5;
   localparam int FPOS_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

   typedef struct packed {
      logic               ins;
      logic               rem;
      logic [CMP_W-1:0]   pos;
      logic [CMP_W-1:0]   count;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

### hw/rtl/bal_cell.sv
// One list cell: holds one entry, shifts to/from its neighbours, compares against the key.
`timescale 1ns / 1ps
module bal_cell
   import bal_pkg::*;
(
   input  logic               clock,
   input  logic [CMP_W-1:0]   cell_index,
   input  cell_ctrl_type      ctrl,
   input  logic [VALUE_W-1:0] left_value,
   input  logic [VALUE_W-1:0] right_value,
   output logic [VALUE_W-1:0] entry_value,
   output logic               match
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (cell_index == ctrl.pos) begin
            entry_in = ctrl.value;
         end else if (cell_index > ctrl.pos && cell_index <= ctrl.count) begin
            entry_in = left_value;
         end
      end else if (ctrl.rem) begin
         if (cell_index >= ctrl.pos && (cell_index + 1'b1) < ctrl.count) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign match       = (cell_index < ctrl.count) && (entry_ff == ctrl.value);

endmodule

### hw/rtl/bounded_array_list.sv
// Top level of the bounded array list: operation decode, cell chain and result register.
// A result beat is valid in the cycle after the request beat is accepted.
// Throughput: one operation per cycle while rsp_ready stays high; every operation
// (insert shift, remove shift, search compare) is applied to the cell chain in the cycle that accepts it.
// Reset clears the entry count and the result valid; entry storage is not cleared.
`timescale 1ns / 1ps
module bounded_array_list
   import bal_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_value_out,
   output logic [FPOS_W-1:0]          rsp_found_position,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_is_full,
   output logic                       rsp_is_empty
);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               status_ff;
   logic               status_in;
   logic [VALUE_W-1:0] value_out_ff;
   logic [VALUE_W-1:0] value_out_in;
   logic [FPOS_W-1:0]  fpos_ff;
   logic [FPOS_W-1:0]  fpos_in;

   cell_ctrl_type      ctrl;
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]   cell_match;

   logic               fire;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic               ins_ok;
   logic               rem_ok;
   logic               hit;
   logic [IDX_W-1:0]   hit_idx;
   logic [VALUE_W-1:0] removed;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign pos_ext   = CMP_W'(req_position);
   assign cnt_ext   = CMP_W'(count_ff);

   always_comb begin
      ins_ok = (req_opcode == OP_INSERT) && (cnt_ext < CMP_W'(DEPTH)) && (pos_ext <= cnt_ext);
      rem_ok = (req_opcode == OP_REMOVE) && (count_ff != '0) && (pos_ext < cnt_ext);
      hit    = |cell_match;

      ctrl.ins   = fire && ins_ok;
      ctrl.rem   = fire && rem_ok;
      ctrl.pos   = pos_ext;
      ctrl.count = cnt_ext;
      ctrl.value = req_value;

      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            hit_idx = IDX_W'(i);
         end
      end

      removed = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CMP_W'(i) == pos_ext) begin
            removed = cell_value[i];
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [VALUE_W-1:0] left_value;
         logic [VALUE_W-1:0] right_value;
         if (g == 0) begin : g_first
            assign left_value = '0;
         end else begin : g_left
            assign left_value = cell_value[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_value = '0;
         end else begin : g_right
            assign right_value = cell_value[g+1];
         end
         bal_cell u_cell (
            .clock       (clock),
            .cell_index  (CMP_W'(g)),
            .ctrl        (ctrl),
            .left_value  (left_value),
            .right_value (right_value),
            .entry_value (cell_value[g]),
            .match       (cell_match[g])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      value_out_in = value_out_ff;
      fpos_in      = fpos_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         status_in    = 1'b1;
         value_out_in = '0;
         fpos_in      = '0;
         unique case (req_opcode)
            OP_INSERT: begin
               if (ins_ok) begin
                  status_in = 1'b0;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (rem_ok) begin
                  status_in    = 1'b0;
                  value_out_in = removed;
                  count_in     = count_ff - 1'b1;
               end
            end
            OP_SEARCH: begin
               if (hit) begin
                  status_in = 1'b0;
                  fpos_in   = FPOS_W'(hit_idx);
               end
            end
            default: begin
               status_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      value_out_ff <= value_out_in;
      fpos_ff      <= fpos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_value_out      = value_out_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_count          = COUNT_W'(count_ff);
   assign rsp_is_full        = (CMP_W'(count_ff) == CMP_W'(DEPTH));
   assign rsp_is_empty       = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted beat gave no result");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff))
      else $error("entry count moved without a request beat");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_is_full && rsp_is_empty))
      else $error("full and empty both set");

endmodule
